/* rtl/cstsr_pkg.sv */
`timescale 1ns / 1ps
package cstsr_pkg;

	localparam int SCHEDULE_ENTRIES = 8;

	localparam int COUNT_W  = 5;
	localparam int TEMP_W   = 7;
	localparam int EPOCH_W  = 32;
	localparam int REMAIN_W = 17;
	localparam int MOD_W    = 11;
	localparam int OFFSET_W = 3;

	localparam logic [EPOCH_W-1:0]  SYNC_EPOCH         = 32'd1600000000;
	localparam logic [11:0]         SEC_PER_HOUR       = 12'd3600;
	localparam logic [OFFSET_W-1:0] SLEEP_MAX_OFFSET_F = 3'd4;
	localparam logic [OFFSET_W-1:0] SLEEP_STEP_F       = 3'd1;
	localparam logic [MOD_W-1:0]    NO_MINUTE          = 11'd2047;
	localparam logic [REMAIN_W-1:0] REMAIN_MAX         = 17'h1FFFF;
	localparam logic [2:0]          WDAY_NONE          = 3'd7;

	localparam logic [TEMP_W-1:0] TEMP_MIN_RESET = 7'd62;
	localparam logic [TEMP_W-1:0] TEMP_MAX_RESET = 7'd86;

	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_START  = 2'd1,
		ACT_CANCEL = 2'd2,
		ACT_LOAD   = 2'd3
	} action_t;

	typedef enum logic {
		REG_TEMP_MIN = 1'b0,
		REG_TEMP_MAX = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic              enabled;
		logic [6:0]        days;
		logic [4:0]        hour;
		logic [5:0]        minute;
		logic              power;
		logic              sleep;
		logic              uses_setpoint;
		logic [TEMP_W-1:0] temp;
	} entry_t;

	typedef struct packed {
		logic [2:0] wday;
		logic [4:0] hour;
		logic [5:0] minute;
	} probe_t;

	typedef struct packed {
		logic               found;
		logic [COUNT_W-1:0] idx;
		logic               power;
		logic               sleep;
		logic               uses_setpoint;
		logic [TEMP_W-1:0]  temp;
	} hit_t;

endpackage

/* rtl/cstsr_if.sv */
`timescale 1ns / 1ps
interface cstsr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] epoch_sec;
	logic [2:0]  weekday;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [6:0]  days_mask;
	logic        power;
	logic        sleep;
	logic        uses_setpoint;
	logic [6:0]  temp_f;
	logic [4:0]  count;
	logic        flag;

	modport source (
		output valid, action, epoch_sec, weekday, hour, minute, days_mask,
		       power, sleep, uses_setpoint, temp_f, count, flag,
		input  ready
	);
	modport sink (
		input  valid, action, epoch_sec, weekday, hour, minute, days_mask,
		       power, sleep, uses_setpoint, temp_f, count, flag,
		output ready
	);
endinterface

interface cstsr_rsp_if;
	logic        valid;
	logic        ready;
	logic        changed;
	logic        power_out;
	logic        sleep_out;
	logic [6:0]  temp_out_f;
	logic        timer_cleared;
	logic        schedule_fired;
	logic [2:0]  schedule_index;
	logic [16:0] timer_remaining_sec;

	modport source (
		output valid, changed, power_out, sleep_out, temp_out_f, timer_cleared,
		       schedule_fired, schedule_index, timer_remaining_sec,
		input  ready
	);
	modport sink (
		input  valid, changed, power_out, sleep_out, temp_out_f, timer_cleared,
		       schedule_fired, schedule_index, timer_remaining_sec,
		output ready
	);
endinterface

interface cstsr_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [6:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/cstsr_cell.sv */
`timescale 1ns / 1ps
module cstsr_cell
	import cstsr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [COUNT_W-1:0] cell_idx,
	input  logic               load,
	input  entry_t             load_entry,
	input  probe_t             probe,
	input  hit_t               hit_in,
	output hit_t               hit_out
);

	logic       enabled_q;
	entry_t     entry_q;
	logic [7:0] days_ext;
	logic       match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (load) begin
			enabled_q <= load_entry.enabled;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= load_entry;
		end
	end

	assign days_ext = {1'b0, entry_q.days};
	assign match = enabled_q && days_ext[probe.wday]
		&& (entry_q.hour == probe.hour) && (entry_q.minute == probe.minute);

	always_comb begin
		hit_out = hit_in;
		if (!hit_in.found && match) begin
			hit_out.found         = 1'b1;
			hit_out.idx           = cell_idx;
			hit_out.power         = entry_q.power;
			hit_out.sleep         = entry_q.sleep;
			hit_out.uses_setpoint = entry_q.uses_setpoint;
			hit_out.temp          = entry_q.temp;
		end
	end

endmodule

/* rtl/cstsr_row.sv */
`timescale 1ns / 1ps
module cstsr_row
	import cstsr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_en,
	input  logic [COUNT_W-1:0] load_idx,
	input  entry_t             load_entry,
	input  probe_t             probe,
	output hit_t               hit
);

	hit_t chain [SCHEDULE_ENTRIES+1];

	assign chain[0] = '0;

	for (genvar i = 0; i < SCHEDULE_ENTRIES; i++) begin : g_cell
		cstsr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_idx   (COUNT_W'(i)),
			.load       (load_en && (load_idx == COUNT_W'(i))),
			.load_entry (load_entry),
			.probe      (probe),
			.hit_in     (chain[i]),
			.hit_out    (chain[i+1])
		);
	end

	assign hit = chain[SCHEDULE_ENTRIES];

endmodule

/* rtl/climate_schedule_timer_sleep_ramp_top.sv */
`timescale 1ns / 1ps
// Air-conditioner time controller. Each request (tick, start timer, cancel timer,
// load schedule entry) yields one result. The accepting edge captures the request;
// the APPLY, PREP and FINISH states then run the timer and schedule rule, then ramp
// preparation and remaining-time calculation, then ramp update and result load,
// after which the result sits in the output register until the consumer takes it.
// One request is in flight at a time; a new one is taken on the edge after the
// previous result is loaded. A loaded result that the consumer has not taken
// holds the next request in its last step. The schedule is a row of cells, one
// per entry, that hands the first match down the row within the rule cycle.
// Register writes are taken at any time and should only be issued while the
// block is idle.
module climate_schedule_timer_sleep_ramp_top
	import cstsr_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	cstsr_req_if.sink   req,
	cstsr_rsp_if.source rsp,
	cstsr_cfg_if.sink   cfg
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPLY,
		ST_PREP,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [TEMP_W-1:0] temp_min_q;
	logic [TEMP_W-1:0] temp_max_q;

	action_t             act_q;
	logic [EPOCH_W-1:0]  t_q;
	logic [2:0]          wday_q;
	logic [4:0]          hour_q;
	logic [5:0]          minute_q;
	logic [6:0]          days_q;
	logic                power_q;
	logic                sleep_q;
	logic                uses_q;
	logic [TEMP_W-1:0]   temp_q;
	logic [COUNT_W-1:0]  count_q;
	logic                flag_q;

	logic [EPOCH_W:0]    deadline_q;
	logic                target_power_q;
	logic [EPOCH_W-1:0]  sleep_start_q;
	logic [TEMP_W-1:0]   sleep_base_q;
	logic [OFFSET_W-1:0] sleep_offset_q;
	logic [MOD_W-1:0]    last_fired_q;

	logic                pw_q;
	logic                sl_q;
	logic                us_q;
	logic [TEMP_W-1:0]   tp_q;
	logic                changed_q;
	logic                cleared_q;
	logic                fired_q;
	logic [COUNT_W-1:0]  fidx_q;
	logic                valid_q;
	logic                later_q;
	logic [OFFSET_W-1:0] target_q;
	logic [REMAIN_W-1:0] rem_q;

	logic                rsp_valid_q;
	logic                rsp_changed_q;
	logic                rsp_power_q;
	logic                rsp_sleep_q;
	logic [TEMP_W-1:0]   rsp_temp_q;
	logic                rsp_cleared_q;
	logic                rsp_fired_q;
	logic [2:0]          rsp_index_q;
	logic [REMAIN_W-1:0] rsp_rem_q;

	entry_t              load_entry;
	probe_t              probe;
	hit_t                hit;
	logic                load_en;
	logic                fire;
	logic                time_valid;
	logic [MOD_W-1:0]    mod;
	logic                sched_take;
	logic [EPOCH_W:0]    start_deadline;
	logic [EPOCH_W-1:0]  ramp_diff;
	logic [OFFSET_W-1:0] steps;
	logic [5:0]          tgt_wide;
	logic [OFFSET_W-1:0] target;
	logic [EPOCH_W:0]    rem_diff;
	logic [REMAIN_W-1:0] rem_next;
	logic [TEMP_W:0]     ramp_sum;
	logic [TEMP_W-1:0]   ramp_temp;
	logic                out_free;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign load_entry = '{
		enabled:       flag_q,
		days:          days_q,
		hour:          hour_q,
		minute:        minute_q,
		power:         power_q,
		sleep:         sleep_q,
		uses_setpoint: uses_q,
		temp:          temp_q
	};
	assign probe   = '{wday: wday_q, hour: hour_q, minute: minute_q};
	assign load_en = (state_q == ST_APPLY) && (act_q == ACT_LOAD);

	cstsr_row u_row (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_en    (load_en),
		.load_idx   (count_q),
		.load_entry (load_entry),
		.probe      (probe),
		.hit        (hit)
	);

	assign fire       = (deadline_q != '0) && ((t_q == '0) || (deadline_q <= {1'b0, t_q}));
	assign time_valid = t_q > SYNC_EPOCH;
	assign mod        = MOD_W'(hour_q) * MOD_W'(60) + MOD_W'(minute_q);
	assign sched_take = time_valid && (wday_q != WDAY_NONE) && (mod != last_fired_q)
		&& hit.found;
	assign start_deadline = {1'b0, t_q} + (EPOCH_W+1)'(count_q) * (EPOCH_W+1)'(SEC_PER_HOUR);

	assign ramp_diff = t_q - sleep_start_q;
	always_comb begin
		steps = '0;
		for (int k = 1; k <= int'(SLEEP_MAX_OFFSET_F); k++) begin
			if (ramp_diff >= EPOCH_W'(k) * EPOCH_W'(SEC_PER_HOUR)) begin
				steps = OFFSET_W'(k);
			end
		end
	end
	assign tgt_wide = 6'(steps) * 6'(SLEEP_STEP_F);
	assign target   = (tgt_wide > 6'(SLEEP_MAX_OFFSET_F)) ? SLEEP_MAX_OFFSET_F
		: tgt_wide[OFFSET_W-1:0];

	assign rem_diff = deadline_q - {1'b0, t_q};
	always_comb begin
		if ((deadline_q == '0) || (t_q == '0) || (deadline_q <= {1'b0, t_q})) begin
			rem_next = '0;
		end else if (rem_diff[EPOCH_W:REMAIN_W] != '0) begin
			rem_next = REMAIN_MAX;
		end else begin
			rem_next = rem_diff[REMAIN_W-1:0];
		end
	end

	assign ramp_sum = {1'b0, sleep_base_q} + (TEMP_W+1)'(target_q);
	always_comb begin
		if (ramp_sum < {1'b0, temp_min_q}) begin
			ramp_temp = temp_min_q;
		end else if (ramp_sum > {1'b0, temp_max_q}) begin
			ramp_temp = temp_max_q;
		end else begin
			ramp_temp = ramp_sum[TEMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_min_q <= TEMP_MIN_RESET;
			temp_max_q <= TEMP_MAX_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_TEMP_MIN: temp_min_q <= cfg.data;
				REG_TEMP_MAX: temp_max_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			act_q          <= ACT_TICK;
			t_q            <= '0;
			wday_q         <= '0;
			hour_q         <= '0;
			minute_q       <= '0;
			days_q         <= '0;
			power_q        <= 1'b0;
			sleep_q        <= 1'b0;
			uses_q         <= 1'b0;
			temp_q         <= '0;
			count_q        <= '0;
			flag_q         <= 1'b0;
			deadline_q     <= '0;
			target_power_q <= 1'b0;
			sleep_start_q  <= '0;
			sleep_base_q   <= '0;
			sleep_offset_q <= '0;
			last_fired_q   <= NO_MINUTE;
			pw_q           <= 1'b0;
			sl_q           <= 1'b0;
			us_q           <= 1'b0;
			tp_q           <= '0;
			changed_q      <= 1'b0;
			cleared_q      <= 1'b0;
			fired_q        <= 1'b0;
			fidx_q         <= '0;
			valid_q        <= 1'b0;
			later_q        <= 1'b0;
			target_q       <= '0;
			rem_q          <= '0;
			rsp_valid_q    <= 1'b0;
			rsp_changed_q  <= 1'b0;
			rsp_power_q    <= 1'b0;
			rsp_sleep_q    <= 1'b0;
			rsp_temp_q     <= '0;
			rsp_cleared_q  <= 1'b0;
			rsp_fired_q    <= 1'b0;
			rsp_index_q    <= '0;
			rsp_rem_q      <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						act_q    <= action_t'(req.action);
						t_q      <= req.epoch_sec;
						wday_q   <= req.weekday;
						hour_q   <= req.hour;
						minute_q <= req.minute;
						days_q   <= req.days_mask;
						power_q  <= req.power;
						sleep_q  <= req.sleep;
						uses_q   <= req.uses_setpoint;
						temp_q   <= req.temp_f;
						count_q  <= req.count;
						flag_q   <= req.flag;
						state_q  <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					pw_q      <= power_q;
					sl_q      <= sleep_q;
					us_q      <= uses_q;
					tp_q      <= temp_q;
					changed_q <= 1'b0;
					cleared_q <= 1'b0;
					fired_q   <= 1'b0;
					fidx_q    <= '0;
					valid_q   <= time_valid;
					case (act_q)
						ACT_START: begin
							if ((count_q == '0) || (t_q == '0)) begin
								deadline_q <= '0;
							end else begin
								deadline_q     <= start_deadline;
								target_power_q <= flag_q;
							end
						end
						ACT_CANCEL: begin
							deadline_q <= '0;
						end
						ACT_TICK: begin
							if (fire) begin
								deadline_q <= '0;
								pw_q       <= target_power_q;
								sl_q       <= sleep_q && target_power_q;
								cleared_q  <= 1'b1;
								changed_q  <= 1'b1;
							end
							if (sched_take) begin
								pw_q         <= hit.power;
								sl_q         <= hit.sleep;
								us_q         <= hit.uses_setpoint;
								tp_q         <= hit.temp;
								last_fired_q <= mod;
								fired_q      <= 1'b1;
								fidx_q       <= hit.idx;
								changed_q    <= 1'b1;
							end
						end
						default: ;
					endcase
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					later_q  <= t_q > sleep_start_q;
					target_q <= target;
					rem_q    <= rem_next;
					state_q  <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						rsp_valid_q   <= 1'b1;
						rsp_changed_q <= changed_q;
						rsp_power_q   <= pw_q;
						rsp_sleep_q   <= sl_q;
						rsp_temp_q    <= tp_q;
						rsp_cleared_q <= cleared_q;
						rsp_fired_q   <= fired_q;
						rsp_index_q   <= fidx_q[2:0];
						rsp_rem_q     <= rem_q;
						if ((act_q == ACT_TICK) && valid_q) begin
							if (!sl_q || !us_q || !pw_q) begin
								sleep_start_q  <= '0;
								sleep_offset_q <= '0;
							end else if (sleep_start_q == '0) begin
								sleep_start_q  <= t_q;
								sleep_base_q   <= tp_q;
								sleep_offset_q <= '0;
							end else if (later_q && (target_q != sleep_offset_q)) begin
								sleep_offset_q <= target_q;
								rsp_temp_q     <= ramp_temp;
								rsp_changed_q  <= 1'b1;
							end
						end
						if (act_q != ACT_TICK) begin
							rsp_changed_q <= 1'b0;
							rsp_power_q   <= 1'b0;
							rsp_sleep_q   <= 1'b0;
							rsp_temp_q    <= '0;
							rsp_cleared_q <= 1'b0;
							rsp_fired_q   <= 1'b0;
							rsp_index_q   <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid               = rsp_valid_q;
	assign rsp.changed             = rsp_changed_q;
	assign rsp.power_out           = rsp_power_q;
	assign rsp.sleep_out           = rsp_sleep_q;
	assign rsp.temp_out_f          = rsp_temp_q;
	assign rsp.timer_cleared       = rsp_cleared_q;
	assign rsp.schedule_fired      = rsp_fired_q;
	assign rsp.schedule_index      = rsp_index_q;
	assign rsp.timer_remaining_sec = rsp_rem_q;

`ifndef SYNTH
	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) && out_free |=> rsp.valid)
		else $error("result not loaded on finish");

	a_flags_imply_changed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.timer_cleared || rsp.schedule_fired) |-> rsp.changed)
		else $error("fired or cleared without changed");

	a_offset_cap: assert property (@(posedge clk) disable iff (!arst_n)
		sleep_offset_q <= SLEEP_MAX_OFFSET_F)
		else $error("sleep offset above cap");

	a_fire_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) && (act_q == ACT_TICK) && fire |=> deadline_q == '0)
		else $error("timer fired but deadline kept");
`endif

endmodule
